// ===== rtl/core/ihh_pkg.sv =====
// ----------------------------------------------------------------------------
// ihh_pkg
// Shared types and codes of the inode holder hash table.
// ----------------------------------------------------------------------------
package ihh_pkg;

    // Item modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_ADDED      = 3'd0;
    localparam logic [2:0] ST_HELD       = 3'd1;
    localparam logic [2:0] ST_HOLD_FULL  = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_CLEARED    = 3'd4;
    localparam logic [2:0] ST_HOLDER     = 3'd5;
    localparam logic [2:0] ST_NONE       = 3'd6;

    localparam int PID_W    = 22;
    localparam int NLO_W    = 64;
    localparam int NHI_W    = 56;
    localparam int CNT_W    = 4;
    // Home index bits kept by the front; wide enough for the largest table
    localparam int HASH_W   = 17;
    localparam logic [63:0] HASH_MUL = 64'd2654435761;

    typedef struct packed {
        logic [1:0]       mode;
        logic [63:0]      device;
        logic [63:0]      inode;
        logic [PID_W-1:0] pid;
        logic [NLO_W-1:0] name_low;
        logic [NHI_W-1:0] name_high;
        logic [CNT_W-1:0] result_limit;
        logic [HASH_W-1:0] hash;
    } cmd_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [NLO_W-1:0] name_low;
        logic [NHI_W-1:0] name_high;
    } holder_t;

    typedef struct packed {
        logic [2:0] status;
        holder_t    holder;
        logic       last;
    } res_t;

endpackage

// ===== rtl/core/ihh_if.sv =====
// ----------------------------------------------------------------------------
// ihh_in_if / ihh_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface ihh_in_if;
    import ihh_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [63:0]      device;
    logic [63:0]      inode;
    logic [PID_W-1:0] pid;
    logic [NLO_W-1:0] name_low;
    logic [NHI_W-1:0] name_high;
    logic [CNT_W-1:0] result_limit;

    modport source (output valid, mode, device, inode, pid, name_low, name_high,
                    result_limit, input ready);
    modport sink (input valid, mode, device, inode, pid, name_low, name_high,
                  result_limit, output ready);
endinterface

interface ihh_out_if;
    import ihh_pkg::*;
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [PID_W-1:0] holder_pid;
    logic [NLO_W-1:0] holder_name_low;
    logic [NHI_W-1:0] holder_name_high;
    logic             last;

    modport source (output valid, status, holder_pid, holder_name_low,
                    holder_name_high, last, input ready);
    modport sink (input valid, status, holder_pid, holder_name_low,
                  holder_name_high, last, output ready);
endinterface

// ===== rtl/core/inode_holder_hash_table.sv =====
// ----------------------------------------------------------------------------
// inode_holder_hash_table
// Open-addressed table of (device, inode) keys, each with a list of holders.
//
//   channel  direction  payload
//   in_ch    sink       mode, device, inode, pid, name_low, name_high, limit
//   out_ch   source     status, holder_pid, holder_name_low/high, last
//
// One item at a time in the back end: a read and a check state per probed
// slot and per holder read from the holder store, plus entry, write and
// result. A clear is set by the sweep of the valid store, one slot per
// cycle, and then gives its result.
// After reset the same sweep runs with in_ch.ready low.
// A stalled out_ch holds the back end; the front and a two-item queue keep
// taking items meanwhile.
// ----------------------------------------------------------------------------
module inode_holder_hash_table #(
    parameter int TABLE_DEPTH      = 4096,
    parameter int PROBE_LIMIT      = 8,
    parameter int HOLDERS_PER_SLOT = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    ihh_in_if.sink    in_ch,
    ihh_out_if.source out_ch
);
    import ihh_pkg::*;

    logic f_valid;
    cmd_t f_data;
    logic f_ready;
    logic q_valid;
    cmd_t q_data;
    logic q_ready;
    logic sweeping;

    ihh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .hold       (sweeping),
        .push_valid (f_valid),
        .push_data  (f_data),
        .push_ready (f_ready)
    );

    ihh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_data  (f_data),
        .push_ready (f_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop_ready  (q_ready)
    );

    ihh_back #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .PROBE_LIMIT      (PROBE_LIMIT),
        .HOLDERS_PER_SLOT (HOLDERS_PER_SLOT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_data  (q_data),
        .cmd_ready (q_ready),
        .out_ch    (out_ch),
        .sweeping  (sweeping)
    );

endmodule

// ===== rtl/core/ihh_front.sv =====
// ----------------------------------------------------------------------------
// ihh_front
// Accepts request items, drops unused modes, trims names at the first zero
// byte and computes the low bits of the home slot hash.
// ----------------------------------------------------------------------------
module ihh_front (
    input  logic          clk,
    input  logic          rst_n,
    ihh_in_if.sink        in_ch,
    input  logic          hold,
    output logic          push_valid,
    output ihh_pkg::cmd_t push_data,
    input  logic          push_ready
);
    import ihh_pkg::*;

    logic        s1_valid_reg;
    cmd_t        s1_reg;
    logic [119:0] name_full;
    logic [119:0] name_trim;
    logic        zero_seen;
    logic [7:0]  name_byte;
    logic [HASH_W-1:0] ino_mul;
    logic [HASH_W-1:0] dev_mul;
    logic        accept;

    // Name trim: bytes after the first zero byte become zero
    always_comb
    begin
        zero_seen = 1'b0;
        name_byte = 8'h00;
        name_full = {in_ch.name_high, in_ch.name_low};
        name_trim = '0;
        for (int b = 0; b < 15; b++)
        begin
            name_byte = name_full[b*8 +: 8];
            name_trim[b*8 +: 8] = zero_seen ? 8'h00 : name_byte;
            if (name_byte == 8'h00)
            begin
                zero_seen = 1'b1;
            end
        end
    end

    assign in_ch.ready = (!s1_valid_reg || push_ready) && !hold;
    assign accept      = in_ch.valid && in_ch.ready;

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= (in_ch.mode != MODE_UNUSED);
                s1_reg.mode         <= in_ch.mode;
                s1_reg.device       <= in_ch.device;
                s1_reg.inode        <= in_ch.inode;
                s1_reg.pid          <= in_ch.pid;
                s1_reg.name_low     <= name_trim[63:0];
                s1_reg.name_high    <= name_trim[119:64];
                s1_reg.result_limit <= in_ch.result_limit;
                s1_reg.hash         <= '0;
            end
            else if (push_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Low hash bits only depend on low operand bits
    assign ino_mul = HASH_W'(s1_reg.inode[HASH_W-1:0] * HASH_MUL[HASH_W-1:0]);
    assign dev_mul = HASH_W'({s1_reg.device[HASH_W-1:0], 5'b00000})
                     - s1_reg.device[HASH_W-1:0];

    always_comb
    begin
        push_data      = s1_reg;
        push_data.hash = ino_mul ^ dev_mul;
    end

    assign push_valid = s1_valid_reg;

endmodule

// ===== rtl/core/ihh_queue.sv =====
// ----------------------------------------------------------------------------
// ihh_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module ihh_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  ihh_pkg::cmd_t push_data,
    output logic          push_ready,
    output logic          pop_valid,
    output ihh_pkg::cmd_t pop_data,
    input  logic          pop_ready
);
    import ihh_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                entry_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/ihh_back.sv =====
// ----------------------------------------------------------------------------
// ihh_back
// Probes the slot store, checks or reports holders, writes new holders and
// sweeps the valid store on reset and clear.
// ----------------------------------------------------------------------------
module ihh_back #(
    parameter int TABLE_DEPTH      = 4096,
    parameter int PROBE_LIMIT      = 8,
    parameter int HOLDERS_PER_SLOT = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  ihh_pkg::cmd_t cmd_data,
    output logic          cmd_ready,
    ihh_out_if.source     out_ch,
    output logic          sweeping
);
    import ihh_pkg::*;

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int HW  = $clog2(TABLE_DEPTH * HOLDERS_PER_SLOT);
    localparam int PCW = $clog2(PROBE_LIMIT + 1);
    localparam logic [CNT_W-1:0] HMAX = CNT_W'(HOLDERS_PER_SLOT);

    typedef struct packed {
        logic [63:0]      device;
        logic [63:0]      inode;
        logic [CNT_W-1:0] count;
    } key_t;

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_SREAD, S_SCHK, S_HREAD, S_HCHK, S_ADD, S_RES, S_QFIN
    } state_t;

    // Stores
    logic    valid_mem [TABLE_DEPTH];
    key_t    key_mem   [TABLE_DEPTH];
    holder_t hold_mem  [TABLE_DEPTH * HOLDERS_PER_SLOT];

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    sweep_reg;
    logic             clear_pend_reg;
    logic [PCW-1:0]   pc_reg;
    logic [HW-1:0]    base_reg;
    logic [HW-1:0]    haddr_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] lim_reg;
    logic [2:0]       st_reg;
    holder_t          pend_reg;
    logic             pend_v_reg;
    logic             out_valid_reg;
    res_t             out_reg;

    logic             vrd_reg;
    key_t             krd_reg;
    holder_t          hrd_reg;

    logic             out_free;
    logic             key_match;
    logic [CNT_W-1:0] n_rd;
    logic [HW-1:0]    base_rd;
    logic             v_we;
    logic [IW-1:0]    v_wa;
    logic             is_insert;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign key_match = (krd_reg.device == cmd_reg.device)
                       && (krd_reg.inode == cmd_reg.inode);
    assign n_rd      = (krd_reg.count > HMAX) ? HMAX : krd_reg.count;
    assign base_rd   = HW'(HW'(idx_reg) * HW'(HOLDERS_PER_SLOT));
    assign is_insert = (cmd_reg.mode == MODE_INSERT);
    assign cmd_ready = (state_reg == S_IDLE);
    assign sweeping  = (state_reg == S_SWEEP);

    assign v_we = (state_reg == S_SWEEP) || (state_reg == S_ADD);
    assign v_wa = (state_reg == S_SWEEP) ? sweep_reg : idx_reg;

    // Store access: one write and one registered read per store
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            valid_mem[v_wa] <= (state_reg == S_ADD);
        end
        if (state_reg == S_ADD)
        begin
            key_mem[idx_reg] <= '{device: cmd_reg.device, inode: cmd_reg.inode,
                                  count: n_reg + CNT_W'(1)};
            hold_mem[base_reg + HW'(n_reg)] <= '{pid: cmd_reg.pid,
                                                name_low: cmd_reg.name_low,
                                                name_high: cmd_reg.name_high};
        end
        vrd_reg <= valid_mem[idx_reg];
        krd_reg <= key_mem[idx_reg];
        hrd_reg <= hold_mem[haddr_reg];
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_reg      <= '0;
            clear_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_v_reg     <= 1'b0;
        end
        else
        begin
            if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + IW'(1);
                    if (sweep_reg == IW'(TABLE_DEPTH - 1))
                    begin
                        st_reg    <= ST_CLEARED;
                        state_reg <= clear_pend_reg ? S_RES : S_IDLE;
                        clear_pend_reg <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg    <= cmd_data;
                        idx_reg    <= cmd_data.hash[IW-1:0];
                        pc_reg     <= '0;
                        cnt_reg    <= '0;
                        pend_v_reg <= 1'b0;
                        lim_reg    <= (cmd_data.result_limit > HMAX) ? HMAX
                                      : cmd_data.result_limit;
                        if (cmd_data.mode == MODE_CLEAR)
                        begin
                            sweep_reg      <= '0;
                            clear_pend_reg <= 1'b1;
                            state_reg      <= S_SWEEP;
                        end
                        else
                        begin
                            state_reg <= S_SREAD;
                        end
                    end
                end
                S_SREAD:
                begin
                    state_reg <= S_SCHK;
                end
                S_SCHK:
                begin
                    base_reg  <= base_rd;
                    haddr_reg <= base_rd;
                    k_reg     <= '0;
                    if (!vrd_reg)
                    begin
                        // Empty slot: claim on insert, end of chain on query
                        n_reg     <= '0;
                        state_reg <= is_insert ? S_ADD : S_QFIN;
                    end
                    else if (!key_match)
                    begin
                        if (pc_reg == PCW'(PROBE_LIMIT - 1))
                        begin
                            st_reg    <= ST_TABLE_FULL;
                            state_reg <= is_insert ? S_RES : S_QFIN;
                        end
                        else
                        begin
                            pc_reg    <= pc_reg + PCW'(1);
                            idx_reg   <= idx_reg + IW'(1);
                            state_reg <= S_SREAD;
                        end
                    end
                    else
                    begin
                        n_reg <= n_rd;
                        if (is_insert)
                        begin
                            state_reg <= (n_rd == '0) ? S_ADD : S_HREAD;
                        end
                        else
                        begin
                            state_reg <= ((n_rd == '0) || (lim_reg == '0)) ? S_QFIN
                                         : S_HREAD;
                        end
                    end
                end
                S_HREAD:
                begin
                    state_reg <= S_HCHK;
                end
                S_HCHK:
                begin
                    if (is_insert)
                    begin
                        if (hrd_reg.pid == cmd_reg.pid)
                        begin
                            st_reg    <= ST_HELD;
                            state_reg <= S_RES;
                        end
                        else if (k_reg + CNT_W'(1) == n_reg)
                        begin
                            st_reg    <= ST_HOLD_FULL;
                            state_reg <= (n_reg >= HMAX) ? S_RES : S_ADD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + CNT_W'(1);
                            haddr_reg <= haddr_reg + HW'(1);
                            state_reg <= S_HREAD;
                        end
                    end
                    else if (hrd_reg.pid == cmd_reg.pid || !pend_v_reg || out_free)
                    begin
                        // Query: the held result goes out once a later one shows up
                        if (hrd_reg.pid != cmd_reg.pid)
                        begin
                            if (pend_v_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_reg <= '{status: ST_HOLDER, holder: pend_reg,
                                             last: 1'b0};
                            end
                            pend_reg   <= hrd_reg;
                            pend_v_reg <= 1'b1;
                        end
                        if ((k_reg + CNT_W'(1) == n_reg) ||
                            ((hrd_reg.pid != cmd_reg.pid) &&
                             (cnt_reg + CNT_W'(1) == lim_reg)))
                        begin
                            state_reg <= S_QFIN;
                        end
                        else
                        begin
                            k_reg     <= k_reg + CNT_W'(1);
                            haddr_reg <= haddr_reg + HW'(1);
                            state_reg <= S_HREAD;
                        end
                        if (hrd_reg.pid != cmd_reg.pid)
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                end
                S_ADD:
                begin
                    st_reg    <= ST_ADDED;
                    state_reg <= S_RES;
                end
                S_RES:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg   <= '{status: st_reg, holder: '0, last: 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                S_QFIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (pend_v_reg)
                        begin
                            out_reg <= '{status: ST_HOLDER, holder: pend_reg, last: 1'b1};
                        end
                        else
                        begin
                            out_reg <= '{status: ST_NONE, holder: '0, last: 1'b1};
                        end
                        pend_v_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.status           = out_reg.status;
    assign out_ch.holder_pid       = out_reg.holder.pid;
    assign out_ch.holder_name_low  = out_reg.holder.name_low;
    assign out_ch.holder_name_high = out_reg.holder.name_high;
    assign out_ch.last             = out_reg.last;

endmodule
